// File: rtl/core/pfs_pkg.sv
`timescale 1ns / 1ps

package pfs_pkg;

   // Framing bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] PAD_BYTE  = 8'hAA;

   // Request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_SLOT  = 1'b1;

   // Configuration register indexes
   localparam logic CSR_HDR_KIND = 1'b0;
   localparam logic CSR_MEAS_ID  = 1'b1;

   // Header sequencing: byte 0 is sync, byte 1 is pad, 2..14 are scrambled
   localparam logic [3:0] HDR_PAD_IDX   = 4'd1;
   localparam logic [3:0] HDR_LAST_IDX  = 4'd14;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      CMD_START,
      CMD_SLOT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
      logic [7:0]   data;
      logic [16:0]  seed;
      logic [31:0]  packet_number;
      logic [6:0]   byte_count;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_HEADER
   } back_state_type;

   typedef struct packed {
      logic [16:0] state;
      logic [7:0]  data;
   } scr_result_type;

   // Scramble one byte MSB first with 1 + x^12 + x^17
   function automatic scr_result_type scramble(input logic [16:0] state,
                                               input logic [7:0] din);
      scr_result_type res;
      logic [16:0]    s;
      logic           o;
      s = state;
      res.data = '0;
      for (int b = 7; b >= 0; b--) begin
         o = din[b] ^ s[16] ^ s[11];
         s = {s[15:0], o};
         res.data[b] = o;
      end
      res.state = s;
      return res;
   endfunction

endpackage

// File: rtl/core/pfs_if.sv
`timescale 1ns / 1ps

interface pfs_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] packet_number;
   logic [16:0] seed;
   logic [6:0]  byte_count;
   logic [7:0]  data_byte;

   modport source (output valid, func, packet_number, seed, byte_count, data_byte,
                   input ready);
   modport sink   (input valid, func, packet_number, seed, byte_count, data_byte,
                   output ready);
endinterface

interface pfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;

   modport source (output valid, tx_byte, last, input ready);
   modport sink   (input valid, tx_byte, last, output ready);
endinterface

// File: rtl/core/pfs_queue.sv
`timescale 1ns / 1ps

module pfs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfs_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output pfs_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(pfs_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pfs_pkg::QUEUE_DEPTH + 1);

   pfs_pkg::cmd_type entry_ff [pfs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(pfs_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/pfs_front.sv
`timescale 1ns / 1ps

module pfs_front #(
   parameter int DATA_BYTES = 113
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [31:0]      req_packet_number,
   input  logic [16:0]      req_seed,
   input  logic [6:0]       req_byte_count,
   input  logic [7:0]       req_data_byte,
   input  logic             queue_full,
   output logic             push,
   output pfs_pkg::cmd_type push_cmd
);

   localparam int IDX_W = $clog2(DATA_BYTES + 1);

   logic             open_ff, open_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             accept;
   logic [6:0]       cnt_sat;
   logic             slot_last;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cnt_sat   = (32'(req_byte_count) > DATA_BYTES) ? 7'(DATA_BYTES) : req_byte_count;
   assign slot_last = (32'(idx_ff) + 32'd1 >= DATA_BYTES);

   // Classify the request and track the open packet
   always_comb begin
      open_in  = open_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      push_cmd.kind          = pfs_pkg::CMD_SLOT;
      push_cmd.last          = slot_last;
      push_cmd.data          = (32'(idx_ff) < 32'(cnt_ff)) ? req_data_byte
                               : pfs_pkg::PAD_BYTE;
      push_cmd.seed          = req_seed;
      push_cmd.packet_number = req_packet_number;
      push_cmd.byte_count    = cnt_sat;
      if (accept) begin
         if (req_func == pfs_pkg::FUNC_START) begin
            open_in       = 1'b1;
            idx_in        = '0;
            cnt_in        = cnt_sat;
            push          = 1'b1;
            push_cmd.kind = pfs_pkg::CMD_START;
            push_cmd.last = 1'b0;
         end else if (open_ff) begin
            push = 1'b1;
            if (slot_last) begin
               open_in = 1'b0;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         idx_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         open_ff <= open_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: rtl/core/pfs_back.sv
`timescale 1ns / 1ps

module pfs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       hdr_kind,
   input  logic [31:0]      measurement_id,
   input  logic             head_valid,
   input  pfs_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last
);

   pfs_pkg::back_state_type state_ff, state_in;
   logic [3:0]              idx_ff, idx_in;
   logic [16:0]             scr_ff, scr_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic                    out_free;
   logic [7:0]              hdr_byte;
   logic [7:0]              scr_src;
   pfs_pkg::scr_result_type scr_out;

   assign out_free = !valid_ff || rsp_ready;

   // Select the header byte for the current position
   always_comb begin
      case (idx_ff)
         4'd2, 4'd3, 4'd4: hdr_byte = pfs_pkg::PAD_BYTE;
         4'd5:             hdr_byte = {5'b0, hdr_kind};
         4'd6:             hdr_byte = measurement_id[7:0];
         4'd7:             hdr_byte = measurement_id[15:8];
         4'd8:             hdr_byte = measurement_id[23:16];
         4'd9:             hdr_byte = measurement_id[31:24];
         4'd10:            hdr_byte = head_cmd.packet_number[7:0];
         4'd11:            hdr_byte = head_cmd.packet_number[15:8];
         4'd12:            hdr_byte = head_cmd.packet_number[23:16];
         4'd13:            hdr_byte = head_cmd.packet_number[31:24];
         4'd14:            hdr_byte = {1'b0, head_cmd.byte_count};
         default:          hdr_byte = pfs_pkg::PAD_BYTE;
      endcase
   end

   assign scr_src = (state_ff == pfs_pkg::BK_IDLE) ? head_cmd.data : hdr_byte;
   assign scr_out = pfs_pkg::scramble(scr_ff, scr_src);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfs_pkg::BK_IDLE: begin
            if (head_valid && out_free && head_cmd.kind == pfs_pkg::CMD_START) begin
               state_in = pfs_pkg::BK_HEADER;
            end
         end
         pfs_pkg::BK_HEADER: begin
            if (out_free && idx_ff == pfs_pkg::HDR_LAST_IDX) begin
               state_in = pfs_pkg::BK_IDLE;
            end
         end
         default: state_in = pfs_pkg::BK_IDLE;
      endcase
   end

   // Produce bytes, advance the scrambler and pop finished commands
   always_comb begin
      pop      = 1'b0;
      idx_in   = idx_ff;
      scr_in   = scr_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      case (state_ff)
         pfs_pkg::BK_IDLE: begin
            if (head_valid && out_free) begin
               valid_in = 1'b1;
               if (head_cmd.kind == pfs_pkg::CMD_START) begin
                  byte_in = pfs_pkg::SYNC_BYTE;
                  last_in = 1'b0;
                  scr_in  = head_cmd.seed;
                  idx_in  = pfs_pkg::HDR_PAD_IDX;
               end else begin
                  byte_in = scr_out.data;
                  last_in = head_cmd.last;
                  scr_in  = scr_out.state;
                  pop     = 1'b1;
               end
            end
         end
         pfs_pkg::BK_HEADER: begin
            if (out_free) begin
               valid_in = 1'b1;
               last_in  = 1'b0;
               idx_in   = idx_ff + 4'd1;
               if (idx_ff == pfs_pkg::HDR_PAD_IDX) begin
                  byte_in = pfs_pkg::PAD_BYTE;
               end else begin
                  byte_in = scr_out.data;
                  scr_in  = scr_out.state;
               end
               if (idx_ff == pfs_pkg::HDR_LAST_IDX) begin
                  pop = 1'b1;
               end
            end
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfs_pkg::BK_IDLE;
         idx_ff   <= '0;
         scr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         scr_ff   <= scr_in;
         valid_ff <= valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_last    = last_ff;

endmodule

// File: rtl/core/packet_framer_scrambler.sv
`timescale 1ns / 1ps

// Packet framer with 1 + x^12 + x^17 self-synchronizing scrambler.
// req_chan takes requests: func 0 opens a packet (packet number, 17-bit seed,
// byte count), func 1 supplies one payload slot. A slot with no open packet
// is dropped. rsp_chan delivers one byte per response, last marks the final
// slot of a packet.
// csr_we/csr_index/csr_wdata set the header type code (index 0) and
// measurement_id (index 1); write them only while the block is idle.
// A start request yields 15 bytes: 0xFF, 0xAA, then 13 scrambled header bytes,
// one per cycle from the back sequencer unless the receiver stalls; the header
// sequencer sets that rate. Each slot request yields one byte, so slots stream
// at one per cycle unless the receiver stalls. The first byte of a request
// passes the queue and then the output register before it is offered. A 4-entry
// command queue lets requests be taken while the header is still going out.
// Reset (synchronous) empties the queue, closes any open packet, clears the
// CSRs and drops rsp valid. When the receiver stalls, the output byte holds,
// the back sequencer waits, and req ready falls once the queue fills.
module packet_framer_scrambler #(
   parameter int DATA_BYTES = 113
) (
   input  logic         clock,
   input  logic         reset,
   pfs_req_if.sink      req_chan,
   pfs_rsp_if.source    rsp_chan,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [2:0]       hdr_kind_ff;
   logic [31:0]      meas_id_ff;
   logic             push;
   pfs_pkg::cmd_type push_cmd;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   pfs_pkg::cmd_type head_cmd;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_kind_ff <= '0;
         meas_id_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pfs_pkg::CSR_HDR_KIND: hdr_kind_ff <= csr_wdata[2:0];
            pfs_pkg::CSR_MEAS_ID:  meas_id_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pfs_front #(
      .DATA_BYTES (DATA_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_func          (req_chan.func),
      .req_packet_number (req_chan.packet_number),
      .req_seed          (req_chan.seed),
      .req_byte_count    (req_chan.byte_count),
      .req_data_byte     (req_chan.data_byte),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   pfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   pfs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .hdr_kind       (hdr_kind_ff),
      .measurement_id (meas_id_ff),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_tx_byte    (rsp_chan.tx_byte),
      .rsp_last       (rsp_chan.last)
   );

endmodule

// File: rtl/core/pfs_checker.sv
`timescale 1ns / 1ps

module pfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   // A pending response stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Reset clears the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // With nothing pending and no new requests, no response appears
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_acc && $past(!req_acc) && !$past(reset) |=> !rsp_valid)
      else $error("response without a request");

endmodule

bind packet_framer_scrambler pfs_checker u_pfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

// File: tb/packet_framer_scrambler_tb.sv
`timescale 1ns / 1ps

module packet_framer_scrambler_tb;

   localparam int CLK_PERIOD    = 12;
   localparam int DATA_BYTES    = 113;
   localparam int MAX_GAP       = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;
   localparam int LONG_HOLD     = 300;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   pfs_req_if req_if ();
   pfs_rsp_if rsp_if ();

   packet_framer_scrambler #(
      .DATA_BYTES (DATA_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted framer state and register copies
   logic [2:0]  cfg_hdr_kind  = '0;
   logic [31:0] cfg_meas_id   = '0;
   logic [16:0] lfsr_state    = '0;
   int unsigned slot_pos      = 0;
   int unsigned slot_count    = 0;
   bit          pkt_open      = 1'b0;

   // Bytes still owed by the framer, oldest first
   frame_byte_type due_bytes[$];

   int unsigned cycle_count   = 0;
   int unsigned bad_bytes     = 0;
   int unsigned bytes_checked = 0;
   int unsigned n_starts      = 0;
   int unsigned n_slots       = 0;
   int unsigned n_dropped     = 0;
   int unsigned n_closed      = 0;
   int unsigned csr_writes    = 0;

   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int rx_wait        = 0;
   int rx_hold_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Scramble one byte MSB first, advancing the predicted register
   function automatic logic [7:0] lfsr_scramble(input logic [7:0] din);
      logic [7:0] dout;
      logic       fb;
      dout = '0;
      for (int b = 7; b >= 0; b--) begin
         fb = din[b] ^ lfsr_state[16] ^ lfsr_state[11];
         lfsr_state = {lfsr_state[15:0], fb};
         dout[b] = fb;
      end
      return dout;
   endfunction

   // Work out the bytes one accepted request must produce
   function automatic void frame_predict(input logic func, input logic [31:0] pnum,
                                         input logic [16:0] seed, input logic [6:0] cnt,
                                         input logic [7:0] dbyte);
      logic [7:0] hdr [13];
      logic [6:0] sat;
      logic [7:0] src;
      logic       at_end;
      if (func == pfs_pkg::FUNC_START) begin
         sat = (cnt > DATA_BYTES) ? 7'(DATA_BYTES) : cnt;
         lfsr_state = seed;
         slot_pos   = 0;
         slot_count = 32'(sat);
         pkt_open   = 1'b1;
         n_starts++;
         hdr[0] = pfs_pkg::PAD_BYTE;
         hdr[1] = pfs_pkg::PAD_BYTE;
         hdr[2] = pfs_pkg::PAD_BYTE;
         hdr[3] = {5'b0, cfg_hdr_kind};
         for (int i = 0; i < 4; i++) begin
            hdr[4 + i] = cfg_meas_id[8 * i +: 8];
            hdr[8 + i] = pnum[8 * i +: 8];
         end
         hdr[12] = {1'b0, sat};
         due_bytes.push_back('{pfs_pkg::SYNC_BYTE, 1'b0});
         due_bytes.push_back('{pfs_pkg::PAD_BYTE, 1'b0});
         for (int i = 0; i < 13; i++)
            due_bytes.push_back('{lfsr_scramble(hdr[i]), 1'b0});
      end else if (!pkt_open) begin
         n_dropped++;
      end else begin
         src    = (slot_pos < slot_count) ? dbyte : pfs_pkg::PAD_BYTE;
         at_end = (slot_pos == DATA_BYTES - 1);
         due_bytes.push_back('{lfsr_scramble(src), at_end});
         n_slots++;
         slot_pos++;
         if (at_end) begin
            pkt_open = 1'b0;
            slot_pos = 0;
            n_closed++;
         end
      end
   endfunction

   // Compare one delivered byte with the oldest prediction
   function automatic void check_byte(input logic [7:0] value, input logic last);
      frame_byte_type want;
      bytes_checked++;
      if (due_bytes.size() == 0) begin
         bad_bytes++;
         if (bad_bytes <= REPORT_LIMIT)
            $display("%0t: unexpected byte %h last %b", $realtime, value, last);
      end else begin
         want = due_bytes.pop_front();
         if (want.value !== value || want.last !== last) begin
            bad_bytes++;
            if (bad_bytes <= REPORT_LIMIT)
               $display("%0t: byte %0d: expected %h last %b, got %h last %b", $realtime,
                        bytes_checked, want.value, want.last, value, last);
         end
      end
   endfunction

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_hdr_kind  = '0;
         cfg_meas_id   = '0;
         lfsr_state    = '0;
         slot_pos      = 0;
         slot_count    = 0;
         pkt_open      = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_byte(rsp_if.tx_byte, rsp_if.last);
            rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (req_if.valid && req_if.ready)
            frame_predict(req_if.func, req_if.packet_number, req_if.seed,
                          req_if.byte_count, req_if.data_byte);
         if (csr_we) begin
            if (csr_index == pfs_pkg::CSR_HDR_KIND)
               cfg_hdr_kind = csr_wdata[2:0];
            else
               cfg_meas_id = csr_wdata;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $realtime, due_bytes.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: after each byte stall for a random gap while rx_idle is set, or hold off for a long stretch on demand
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rsp_if.ready = 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Offer one request, after a random gap while tx_idle is set, and hold it until taken
   task automatic send_request(input logic func, input logic [31:0] pnum,
                               input logic [16:0] seed, input logic [6:0] cnt,
                               input logic [7:0] dbyte);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.func          = func;
      req_if.packet_number = pnum;
      req_if.seed          = seed;
      req_if.byte_count    = cnt;
      req_if.data_byte     = dbyte;
      req_if.valid         = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_start(input logic [31:0] pnum, input logic [16:0] seed,
                             input logic [6:0] cnt);
      send_request(pfs_pkg::FUNC_START, pnum, seed, cnt, 8'($urandom));
   endtask

   task automatic send_slot(input logic [7:0] dbyte);
      send_request(pfs_pkg::FUNC_SLOT, $urandom, 17'($urandom), 7'($urandom), dbyte);
   endtask

   // Drop valid and wait until every predicted byte has arrived
   task automatic wait_for_idle();
      req_if.valid = 1'b0;
      while (due_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      csr_writes++;
   endtask

   // Slots with no open packet must vanish
   task automatic test_stray_slots();
      send_slot(8'h00);
      send_slot(8'hFF);
      wait_for_idle();
   endtask

   // Field extremes, count saturation, odd type codes, abandoning a packet
   task automatic test_header_extremes();
      write_csr(pfs_pkg::CSR_HDR_KIND, 32'd7);
      write_csr(pfs_pkg::CSR_MEAS_ID, 32'hFFFF_FFFF);
      send_start(32'hFFFF_FFFF, 17'h1FFFF, 7'd127);
      send_slot(8'hFF);
      send_slot(8'h00);
      wait_for_idle();
      write_csr(pfs_pkg::CSR_HDR_KIND, 32'd6);
      write_csr(pfs_pkg::CSR_MEAS_ID, 32'h0);
      send_start(32'h0, 17'h0, 7'd0);
      send_slot(8'h5A);
      send_slot(8'hFF);
      send_start(32'h8000_0001, 17'h00001, 7'd113);
      send_slot(8'h01);
      send_slot(8'h80);
      send_start(32'h5555_AAAA, 17'h10800, 7'd114);
      send_slot(8'hAA);
      send_start(32'hAAAA_5555, 17'h0F7FF, 7'd112);
      send_slot(8'h55);
      wait_for_idle();
      write_csr(pfs_pkg::CSR_HDR_KIND, 32'd5);
      write_csr(pfs_pkg::CSR_MEAS_ID, 32'hA5C3_3C5A);
      send_start(32'h0000_00FF, 17'h0_0800, 7'd1);
      send_slot(8'hC3);
      send_slot(8'h3C);
      wait_for_idle();
   endtask

   // Packet stays open across a full drain of the output
   task automatic test_sender_pause();
      send_start($urandom, 17'($urandom), 7'd4);
      repeat (3) send_slot(8'($urandom));
      wait_for_idle();
      repeat (3) send_slot(8'($urandom));
      wait_for_idle();
   endtask

   // Complete packets through the final slot, then a stray slot
   task automatic test_full_packets(input int count);
      repeat (count) begin
         send_start($urandom, 17'($urandom), 7'($urandom_range(0, 127)));
         repeat (DATA_BYTES) send_slot(8'($urandom));
         send_slot(8'($urandom));
      end
      wait_for_idle();
   endtask

   // Hold the output off long enough that the request side must stall
   task automatic test_backpressure();
      tx_idle        = 1'b0;
      rx_hold_cycles = LONG_HOLD;
      send_start($urandom, 17'($urandom), 7'($urandom_range(0, 127)));
      repeat (40) send_slot(8'($urandom));
      tx_idle = 1'b1;
      wait_for_idle();
   endtask

   // Mostly full packets, with abandoned packets, stray slots and new settings
   task automatic test_random_mix(input int target);
      int  counted;
      int  n;
      int  left;
      bit  pkt_live;
      counted  = 0;
      left     = 0;
      pkt_live = 1'b0;
      while (counted < target) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_for_idle();
            write_csr(pfs_pkg::CSR_HDR_KIND, $urandom_range(0, 7));
            write_csr(pfs_pkg::CSR_MEAS_ID, $urandom);
         end
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               // noise: dropped while closed, otherwise one more slot
               if (!pkt_live) begin
                  repeat ($urandom_range(1, 3)) send_slot(8'($urandom));
               end else begin
                  send_slot(8'($urandom));
                  counted++;
                  left--;
                  if (left == 0)
                     pkt_live = 1'b0;
               end
            end
            2, 3, 4: begin
               // broken: start a packet and leave it for the next start
               n = $urandom_range(0, 12);
               send_start($urandom, 17'($urandom), 7'($urandom_range(0, 127)));
               repeat (n) send_slot(8'($urandom));
               counted += n + 1;
               pkt_live = 1'b1;
               left     = DATA_BYTES - n;
            end
            default: begin
               send_start($urandom, 17'($urandom), 7'($urandom_range(0, 127)));
               repeat (DATA_BYTES) send_slot(8'($urandom));
               counted += DATA_BYTES + 1;
               pkt_live = 1'b0;
            end
         endcase
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      wait_for_idle();
   endtask

   initial begin
      csr_we               = 1'b0;
      csr_index            = pfs_pkg::CSR_HDR_KIND;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.func          = pfs_pkg::FUNC_START;
      req_if.packet_number = '0;
      req_if.seed          = '0;
      req_if.byte_count    = '0;
      req_if.data_byte     = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_stray_slots();
      test_header_extremes();
      test_sender_pause();
      test_full_packets(1);
      test_backpressure();
      test_random_mix(150);
      wait_for_idle();

      $display("Sent %0d packet starts and %0d payload slots, %0d stray slots dropped,",
               n_starts, n_slots, n_dropped);
      $display("%0d packets closed; checked %0d bytes over %0d register writes, %0d mismatches.",
               n_closed, bytes_checked, csr_writes, bad_bytes);
      if (bad_bytes == 0 && due_bytes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
